// ===== design/delimiter_stream_splitter_defines.svh =====
// assertion macros for the delimiter stream splitter
// used by the top level only; bodies are empty when SYNTHESIS is defined
`ifndef DELIMITER_STREAM_SPLITTER_DEFINES_SVH
`define DELIMITER_STREAM_SPLITTER_DEFINES_SVH
`ifndef SYNTHESIS
`define DSS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("dss assertion failed");
`define DSS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("dss assertion failed");
`else
`define DSS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define DSS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ===== design/dss_pkg.sv =====
// shared types and constants of the delimiter stream splitter
// no dependencies
package dss_pkg;

    localparam int MAX_DELIM   = 8;
    localparam int WIN_DEPTH   = 8;
    localparam int MAX_RESULTS = 7;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int N_W         = 3;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 64;

    localparam logic [CNT_W-1:0]  LEN_RESET   = 4'd1;
    localparam logic [DATA_W-1:0] DELIM_RESET = 64'd10;

    // register select, taken from the 8-byte aligned address
    localparam logic REG_LEN   = 1'b0;
    localparam logic REG_BYTES = 1'b1;

    typedef logic [7:0] data_t;

    typedef struct packed {
        logic [WIN_DEPTH-1:0][7:0] win;
        logic [CNT_W-1:0]          cnt;
        logic [N_W-1:0]            n;
        logic                      eos;
    } work_t;

    typedef struct packed {
        logic  has_res;
        data_t res_byte;
        logic  res_valid;
        logic  res_end;
        logic  res_last;
        logic  done;
        logic  seg_nxt;
        work_t nxt;
    } step_t;

endpackage

// ===== design/dss_apb_regs.sv =====
// apb configuration registers: delimiter length and delimiter bytes
// depends on dss_pkg
module dss_apb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dss_pkg::ADDR_W-1:0] paddr,
    input  logic [dss_pkg::DATA_W-1:0] pwdata,
    output logic [dss_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [dss_pkg::CNT_W-1:0]  len_cfg,
    output logic [dss_pkg::DATA_W-1:0] delim_cfg
);
    import dss_pkg::*;

    logic [CNT_W-1:0]  len_reg;
    logic [DATA_W-1:0] delim_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_RESET;
            delim_reg <= DELIM_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[ADDR_W-1])
                REG_LEN:   len_reg   <= pwdata[CNT_W-1:0];
                REG_BYTES: delim_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1])
            REG_LEN:   prdata = {{(DATA_W-CNT_W){1'b0}}, len_reg};
            REG_BYTES: prdata = delim_reg;
            default:   prdata = '0;
        endcase
    end

    assign len_cfg   = len_reg;
    assign delim_cfg = delim_reg;

endmodule

// ===== design/dss_step.sv =====
// one step of the splitter: when idle, loads an item into the window, then one compare and shift
// depends on dss_pkg
module dss_step (
    input  logic                       busy,
    input  dss_pkg::work_t             work_in,
    input  logic                       seg_in,
    input  logic                       in_type,
    input  dss_pkg::data_t             in_byte,
    input  logic [dss_pkg::CNT_W-1:0]  len_cfg,
    input  logic [dss_pkg::DATA_W-1:0] delim,
    output dss_pkg::step_t             step
);
    import dss_pkg::*;

    work_t                     cur;
    logic [CNT_W-1:0]          len_sat;
    logic [CNT_W-1:0]          sh;
    logic [CNT_W-1:0]          new_cnt;
    logic [WIN_DEPTH-1:0][7:0] win_sh;
    logic                      hit;
    logic                      more;

    assign len_sat = (len_cfg > CNT_W'(MAX_DELIM)) ? CNT_W'(MAX_DELIM) : len_cfg;

    always_comb
    begin
        more = 1'b0;

        // working window: a running item, or the held bytes plus the new item
        cur = work_in;
        if (!busy)
        begin
            cur.n   = '0;
            cur.eos = in_type;
            if (!in_type)
            begin
                cur.win[work_in.cnt[IDX_W-1:0]] = in_byte;
                cur.cnt = work_in.cnt + CNT_W'(1);
            end
        end

        hit = (len_sat != '0);
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            if ((CNT_W'(i) < len_sat) && (cur.win[i] != delim[8*i +: 8]))
                hit = 1'b0;
        end
        if (cur.eos)
            hit = 1'b0;

        sh      = hit ? len_sat : CNT_W'(1);
        win_sh  = cur.win >> {sh, 3'b000};
        new_cnt = (cur.cnt == '0) ? '0 : cur.cnt - sh;

        step          = '0;
        step.nxt      = cur;
        step.seg_nxt  = seg_in;

        if (cur.eos)
        begin
            // flush held bytes, no delimiter search
            step.has_res   = (cur.cnt != '0) || seg_in;
            step.res_byte  = (cur.cnt != '0) ? cur.win[0] : '0;
            step.res_valid = (cur.cnt != '0);
            step.res_end   = (cur.cnt <= CNT_W'(1));
            step.done      = (cur.cnt <= CNT_W'(1));
            step.nxt.win   = win_sh;
            step.nxt.cnt   = new_cnt;
            step.nxt.n     = cur.n + N_W'(1);
            if (step.done)
            begin
                step.nxt.win = '0;
                step.nxt.cnt = '0;
                step.seg_nxt = 1'b0;
            end
        end
        else
        begin
            step.has_res = (cur.cnt != '0) && (cur.cnt >= len_sat);
            more = (cur.n != N_W'(MAX_RESULTS - 1)) && (new_cnt != '0) && (new_cnt >= len_sat);
            if (step.has_res)
            begin
                step.res_byte  = hit ? '0 : cur.win[0];
                step.res_valid = !hit;
                step.res_end   = hit;
                step.done      = !more;
                step.seg_nxt   = !hit;
                step.nxt.win   = win_sh;
                step.nxt.cnt   = new_cnt;
                step.nxt.n     = cur.n + N_W'(1);
            end
            else
            begin
                // window still shorter than the delimiter: keep the bytes
                step.done = 1'b1;
            end
        end
        step.res_last = step.has_res && step.done;
    end

endmodule

// ===== design/delimiter_stream_splitter.sv =====
// delimiter stream splitter top level: input register, step engine, output register
// depends on dss_pkg, dss_apb_regs, dss_step and delimiter_stream_splitter_defines.svh
// an accepted item goes through the input register and step engine to the output register
// throughput: one result per cycle unless m_tready stalls; items hold the engine until done
// reset: async, clears the window and handshake state; length 1, delimiter 0x0a
`include "delimiter_stream_splitter_defines.svh"
module delimiter_stream_splitter (
    input  logic                       clk,
    input  logic                       rst_n,
    // apb configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dss_pkg::ADDR_W-1:0] paddr,
    input  logic [dss_pkg::DATA_W-1:0] pwdata,
    output logic [dss_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // input items
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  logic                       s_tuser,   // [0] req_type
    // result items
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] out_byte
    output logic [1:0]                 m_tuser,   // [0] byte_valid, [1] segment_end
    output logic                       m_tlast    // last_of_run
);
    import dss_pkg::*;

    logic [CNT_W-1:0]  len_cfg;
    logic [DATA_W-1:0] delim_cfg;

    logic   in_valid_reg;
    logic   in_type_reg;
    data_t  in_byte_reg;

    logic   busy_reg;
    work_t  work_reg;
    logic   seg_reg;
    step_t  step;

    logic   m_tvalid_reg;
    data_t  m_tdata_reg;
    logic [1:0] m_tuser_reg;
    logic   m_tlast_reg;

    logic   out_free;
    logic   advance;
    logic   in_take;

    dss_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .len_cfg   (len_cfg),
        .delim_cfg (delim_cfg)
    );

    dss_step u_step (
        .busy    (busy_reg),
        .work_in (work_reg),
        .seg_in  (seg_reg),
        .in_type (in_type_reg),
        .in_byte (in_byte_reg),
        .len_cfg (len_cfg),
        .delim   (delim_cfg),
        .step    (step)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = (busy_reg || in_valid_reg) && out_free;
    assign in_take  = !busy_reg && in_valid_reg && advance;
    assign s_tready = !in_valid_reg || in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            busy_reg     <= 1'b0;
            work_reg     <= '0;
            seg_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (in_take)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                busy_reg <= !step.done;
                work_reg <= step.nxt;
                seg_reg  <= step.seg_nxt;
            end

            if (out_free)
                m_tvalid_reg <= advance && step.has_res;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_type_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (out_free)
        begin
            m_tdata_reg <= step.res_byte;
            m_tuser_reg <= {step.res_end, step.res_valid};
            m_tlast_reg <= step.res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `DSS_ASSERT_IMP(a_held_fits, clk, rst_n, !busy_reg, work_reg.cnt < CNT_W'(WIN_DEPTH))
    `DSS_ASSERT_IMP(a_busy_has_result, clk, rst_n, busy_reg, (work_reg.n != '0) && (work_reg.n < N_W'(MAX_RESULTS)))
    `DSS_ASSERT_IMP(a_empty_is_end, clk, rst_n, m_tvalid && !m_tuser[0], m_tuser[1])
    `DSS_ASSERT_NXT(a_eos_clears, clk, rst_n, advance && step.nxt.eos && step.done, (work_reg.cnt == '0) && !seg_reg && !busy_reg)

endmodule
